[rtl/crd_pkg.sv]
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types and constants of the checksummed reply deframer: frame header
// codes, result kinds, configuration register indexes and state structs.
// ----------------------------------------------------------------------------
package crd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned CFG_INDEX_W = 2;

    // Frame header bytes
    localparam logic [BYTE_W-1:0] SYNC_FIRST   = 8'hAE;
    localparam logic [BYTE_W-1:0] SYNC_SECOND  = 8'hD0;
    localparam logic [BYTE_W-1:0] DIR_REPLY    = 8'h02;
    localparam logic [BYTE_W-1:0] HEADER_BYTES = 8'd6;
    // Position of the first byte after the header, where the header verdict falls
    localparam logic [BYTE_W-1:0] HEADER_LAST  = 8'd5;

    // Header byte positions
    localparam logic [2:0] POS_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] POS_SYNC_SECOND = 3'd1;
    localparam logic [2:0] POS_LENGTH      = 3'd2;
    localparam logic [2:0] POS_COMMAND     = 3'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_COMMAND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_CAPACITY = 2'd1;

    localparam logic [BYTE_W-1:0] CAPACITY_RESET = 8'd249;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_OK         = 3'd1,
        KIND_CKSUM_BAD  = 3'd2,
        KIND_HEADER_BAD = 3'd3,
        KIND_LENGTH_BAD = 3'd4
    } t_kind;

    // Per-frame receive state
    typedef struct packed {
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] running_sum;
        logic [BYTE_W-1:0] frame_length;
        logic              header_ok;
    } t_frame_state;

    localparam t_frame_state FRAME_CLEAR = '{
        byte_count:   '0,
        running_sum:  '0,
        frame_length: '0,
        header_ok:    1'b1
    };

    // One result item
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] payload_index;
    } t_result;

endpackage

[rtl/checksummed_reply_deframer_unit.sv]
// ----------------------------------------------------------------------------
// checksummed_reply_deframer_unit
// Receives reply bytes, checks header and additive checksum, passes payload.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle while the output accepts results; output
// back-pressure stalls the input. Each byte passes an input register, one step
// of header compare and 8-bit sum, and an output register, in that order.
// A frame is AE D0, length, command, direction 02, payload, checksum.
// Payload bytes leave with tuser = 0, verdicts with tuser = 1 (ok, count in
// tdata[7:0]), 2 (checksum bad), 3 (header rejected), 4 (length under six).
// tuser bit 0 on the input restarts the frame at that byte. Write the command
// and capacity registers only while no bytes are in flight.
// ----------------------------------------------------------------------------
module checksummed_reply_deframer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [crd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [crd_pkg::BYTE_W-1:0]       i_cfg_data,
    // Byte input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] rx_byte
    input  logic                             i_s_tuser,   // [0] restart
    // Result output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [15:0]                      o_m_tdata,   // [7:0] value, [15:8] payload_index
    output logic [crd_pkg::KIND_W-1:0]       o_m_tuser    // [2:0] kind
);
    import crd_pkg::*;

    logic [BYTE_W-1:0] r_expected_command;
    logic [BYTE_W-1:0] r_payload_capacity;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_restart;

    t_frame_state      r_state;
    t_frame_state      n_state;
    logic              step_valid;
    t_result           step_result;

    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              proc_fire;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    assign proc_fire   = r_in_valid && out_free;
    assign o_s_tready  = !r_in_valid || proc_fire;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_command <= '0;
            r_payload_capacity <= CAPACITY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_EXPECTED_COMMAND) r_expected_command <= i_cfg_data;
            if (i_cfg_index == CFG_PAYLOAD_CAPACITY) r_payload_capacity <= i_cfg_data;
        end
    end

    // Input register: hold a request until the step can run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte    <= i_s_tdata;
            r_in_restart <= i_s_tuser;
        end
    end

    crd_step u_step (
        .i_state            (r_state),
        .i_rx_byte          (r_in_byte),
        .i_restart          (r_in_restart),
        .i_expected_command (r_expected_command),
        .i_payload_capacity (r_payload_capacity),
        .o_state            (n_state),
        .o_result_valid     (step_valid),
        .o_result           (step_result)
    );

    // Frame state advances once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRAME_CLEAR;
        end else if (proc_fire) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_fire && step_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && step_valid) begin
            r_out <= step_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {r_out.payload_index, r_out.value};

    // A verdict always leaves the receiver cleared
    a_verdict_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && step_valid && (step_result.kind != KIND_PAYLOAD)
        |=> (r_state.byte_count == '0) && r_state.header_ok)
        else $error("frame state not cleared after verdict");

    // Inside the payload the count stays below the frame length
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.byte_count > HEADER_LAST) |-> (r_state.frame_length > r_state.byte_count))
        else $error("byte count ran past frame length");

    // Payload results only below capacity
    a_payload_in_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == KIND_PAYLOAD)
        |-> (r_out.payload_index < r_payload_capacity))
        else $error("payload byte beyond capacity");

    // Input side stalls only with a byte held
    a_stall_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && r_out_valid && !i_m_tready)
        else $error("input stalled without cause");

endmodule

[rtl/crd_step.sv]
// ----------------------------------------------------------------------------
// crd_step
// Next-state and result logic for one received byte: header compares,
// running checksum, payload passing and frame verdicts.
// ----------------------------------------------------------------------------
module crd_step (
    input  crd_pkg::t_frame_state       i_state,
    input  logic [crd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_restart,
    input  logic [crd_pkg::BYTE_W-1:0]  i_expected_command,
    input  logic [crd_pkg::BYTE_W-1:0]  i_payload_capacity,
    output crd_pkg::t_frame_state       o_state,
    output logic                        o_result_valid,
    output crd_pkg::t_result            o_result
);
    import crd_pkg::*;

    t_frame_state      cur;
    logic [BYTE_W-1:0] pos;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] payload_len;
    logic [BYTE_W-1:0] payload_idx;
    logic              at_verdict;
    logic              at_end;

    // Restart clears the frame before this byte is looked at
    assign cur         = i_restart ? FRAME_CLEAR : i_state;
    assign pos         = cur.byte_count;
    assign sum_next    = cur.running_sum + i_rx_byte;
    assign payload_len = cur.frame_length - HEADER_BYTES;
    assign payload_idx = pos - HEADER_LAST;
    assign at_verdict  = (pos == HEADER_LAST);
    assign at_end      = (pos == cur.frame_length - 8'd1);

    always_comb begin
        o_state        = cur;
        o_result_valid = 1'b0;
        o_result       = '{kind: KIND_PAYLOAD, value: '0, payload_index: '0};

        priority if (pos < HEADER_LAST) begin
            // Compare header bytes, capture the length
            unique case (pos[2:0])
                POS_SYNC_FIRST:  if (i_rx_byte != SYNC_FIRST)  o_state.header_ok = 1'b0;
                POS_SYNC_SECOND: if (i_rx_byte != SYNC_SECOND) o_state.header_ok = 1'b0;
                POS_LENGTH:      o_state.frame_length = i_rx_byte;
                POS_COMMAND:     if (i_rx_byte != i_expected_command) o_state.header_ok = 1'b0;
                default:         if (i_rx_byte != DIR_REPLY)   o_state.header_ok = 1'b0;
            endcase
            o_state.running_sum = sum_next;
            o_state.byte_count  = pos + 8'd1;
        end else if (at_verdict && !cur.header_ok) begin
            // Drop the frame on a header mismatch
            o_state        = FRAME_CLEAR;
            o_result_valid = 1'b1;
            o_result.kind  = KIND_HEADER_BAD;
        end else if (at_verdict && (cur.frame_length < HEADER_BYTES)) begin
            o_state        = FRAME_CLEAR;
            o_result_valid = 1'b1;
            o_result.kind  = KIND_LENGTH_BAD;
        end else if (at_end) begin
            // Checksum byte: give the frame verdict
            o_state        = FRAME_CLEAR;
            o_result_valid = 1'b1;
            if (cur.running_sum == i_rx_byte) begin
                o_result.kind  = KIND_OK;
                o_result.value = (payload_len > i_payload_capacity) ? i_payload_capacity
                                                                     : payload_len;
            end else begin
                o_result.kind  = KIND_CKSUM_BAD;
            end
        end else begin
            // Payload byte: pass on while under capacity
            o_state.running_sum = sum_next;
            o_state.byte_count  = pos + 8'd1;
            if (payload_idx < i_payload_capacity) begin
                o_result_valid         = 1'b1;
                o_result.kind          = KIND_PAYLOAD;
                o_result.value         = i_rx_byte;
                o_result.payload_index = payload_idx;
            end
        end
    end

endmodule

[tb/checksummed_reply_deframer_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checksummed_reply_deframer_unit_test
// Self-checking bench for the reply deframer. Replies are fed in byte by byte.
// A short hand-written frame table comes first, then random frames under
// several command and capacity settings: well-formed frames, broken headers,
// short lengths, bad checksums, cut-off frames and line noise. A model of the
// receiver kept in step with accepted bytes predicts each result that the table
// does not give, and every result is checked field by field in order. Both
// ends idle at random, and one long output stall backs the unit up.
// ----------------------------------------------------------------------------
module checksummed_reply_deframer_unit_test;
    import crd_pkg::*;

    localparam int unsigned CLK_HALF        = 6;
    localparam int unsigned RESET_CYCLES    = 11;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned LONG_HOLD       = 80;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned ITEMS_PER_PHASE = 215;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned NUM_DIRECTED    = 25;

    // One row of the hand-written byte table
    typedef struct packed {
        logic       restart;
        logic [7:0] rx_byte;
        logic       typed;
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] index;
    } t_stim_row;

    // Frames under reset settings (command 0, capacity 249):
    // good frame with one payload byte, command mismatch, length 0, bad checksum
    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{1'b1, 8'hAE, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'hD0, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h07, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h00, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h02, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h55, 1'b1, KIND_PAYLOAD,    8'h55, 8'h00},
        '{1'b0, 8'hDC, 1'b1, KIND_OK,         8'h01, 8'h00},
        '{1'b0, 8'hAE, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'hD0, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h07, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'hFF, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h02, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h00, 1'b1, KIND_HEADER_BAD, 8'h00, 8'h00},
        '{1'b0, 8'hAE, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'hD0, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h00, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h00, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h02, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'hFF, 1'b1, KIND_LENGTH_BAD, 8'h00, 8'h00},
        '{1'b0, 8'hAE, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'hD0, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h06, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h00, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'h02, 1'b0, KIND_PAYLOAD,    8'h00, 8'h00},
        '{1'b0, 8'hFF, 1'b1, KIND_CKSUM_BAD,  8'h00, 8'h00}
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]      i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata   = '0;
    logic                   i_s_tuser   = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [15:0]            o_m_tdata;
    logic [KIND_W-1:0]      o_m_tuser;

    // Receiver model: settings and per-frame state
    logic [7:0] model_cmd;
    logic [7:0] model_cap;
    logic [7:0] rx_count;
    logic [7:0] rx_sum;
    logic [7:0] rx_len;
    logic       rx_hdr_ok;

    t_result     awaited_results[$];
    t_result     head_result;
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned cycle_count    = 0;
    bit          idle_on        = 1'b1;
    bit          long_hold_req  = 1'b0;
    bit          resync_due     = 1'b0;

    checksummed_reply_deframer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [7:0] rx_byte
        .i_s_tuser   (i_s_tuser),   // [0] restart
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [7:0] value, [15:8] payload_index
        .o_m_tuser   (o_m_tuser)    // [2:0] kind
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void clear_rx_state();
        rx_count  = '0;
        rx_sum    = '0;
        rx_len    = '0;
        rx_hdr_ok = 1'b1;
    endfunction

    // Advance the receiver model by one byte; return 1 when it yields a result
    function automatic bit deframe_byte(input logic restart, input logic [7:0] b,
                                        output t_result res);
        logic [7:0] pos;
        logic [7:0] idx;
        logic [7:0] count;
        logic       good;
        res = '0;
        if (restart) clear_rx_state();
        pos = rx_count;
        // Header bytes: compare and accumulate
        if (pos < HEADER_LAST) begin
            case (pos[2:0])
                POS_SYNC_FIRST:  if (b != SYNC_FIRST) rx_hdr_ok = 1'b0;
                POS_SYNC_SECOND: if (b != SYNC_SECOND) rx_hdr_ok = 1'b0;
                POS_LENGTH:      rx_len = b;
                POS_COMMAND:     if (b != model_cmd) rx_hdr_ok = 1'b0;
                default:         if (b != DIR_REPLY) rx_hdr_ok = 1'b0;
            endcase
            rx_sum   = rx_sum + b;
            rx_count = pos + 8'd1;
            return 1'b0;
        end
        // Header verdict at the sixth byte
        if (pos == HEADER_LAST) begin
            if (!rx_hdr_ok) begin
                clear_rx_state();
                res.kind = KIND_HEADER_BAD;
                return 1'b1;
            end
            if (rx_len < HEADER_BYTES) begin
                clear_rx_state();
                res.kind = KIND_LENGTH_BAD;
                return 1'b1;
            end
        end
        // Checksum byte closes the frame
        if (pos == rx_len - 8'd1) begin
            good  = (rx_sum == b);
            count = rx_len - HEADER_BYTES;
            if (count > model_cap) count = model_cap;
            clear_rx_state();
            if (good) begin
                res.kind  = KIND_OK;
                res.value = count;
            end else begin
                res.kind = KIND_CKSUM_BAD;
            end
            return 1'b1;
        end
        // Payload byte, passed on below capacity
        idx      = pos - HEADER_LAST;
        rx_sum   = rx_sum + b;
        rx_count = pos + 8'd1;
        if (idx < model_cap) begin
            res.kind          = KIND_PAYLOAD;
            res.value         = b;
            res.payload_index = idx;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one byte, wait for the request to be taken, then predict
    task automatic send_byte(input logic restart, input logic [7:0] rx_byte,
                             input bit typed, input t_result typed_res);
        int unsigned gap;
        t_result     predicted;
        bit          got;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rx_byte;
        i_s_tuser  <= restart;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
        got = deframe_byte(restart, rx_byte, predicted);
        if (typed) awaited_results.push_back(typed_res);
        else if (got) awaited_results.push_back(predicted);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_EXPECTED_COMMAND: model_cmd = data;
            CFG_PAYLOAD_CAPACITY: model_cap = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering bytes and let every pending result come out
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Send one random frame: mostly well-formed, some broken, some noise
    task automatic send_random_frame(input bit big);
        logic [7:0]  frame_q[$];
        logic [7:0]  sum;
        int unsigned plen;
        int unsigned flavor;
        int unsigned n_send;
        int unsigned hdr_slot;
        logic        first_restart;
        frame_q = {};
        flavor  = $urandom_range(0, 99);
        // Line noise with random restarts
        if (flavor >= 96) begin
            repeat ($urandom_range(1, 8)) begin
                send_byte(1'($urandom_range(0, 2) == 0), 8'($urandom_range(0, 255)),
                          1'b0, '0);
            end
            resync_due = 1'b1;
            return;
        end
        if (big) plen = $urandom_range(200, 249);
        else if ($urandom_range(0, 99) < 85) plen = $urandom_range(0, 12);
        else plen = $urandom_range(13, 60);
        frame_q.push_back(SYNC_FIRST);
        frame_q.push_back(SYNC_SECOND);
        frame_q.push_back(8'(plen + 6));
        frame_q.push_back(model_cmd);
        frame_q.push_back(DIR_REPLY);
        repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
        sum = '0;
        foreach (frame_q[k]) sum = sum + frame_q[k];
        frame_q.push_back(sum);
        n_send        = frame_q.size();
        first_restart = 1'(resync_due || $urandom_range(0, 3) == 0);
        resync_due    = 1'b0;
        if (flavor >= 72 && flavor < 80) begin
            // Corrupt the checksum
            frame_q[n_send-1] = sum ^ 8'($urandom_range(1, 255));
        end else if (flavor >= 80 && flavor < 88) begin
            // Corrupt sync, command or direction; the tail becomes noise
            hdr_slot = $urandom_range(0, 3);
            if (hdr_slot >= 2) hdr_slot++;
            frame_q[hdr_slot] = frame_q[hdr_slot] ^ 8'($urandom_range(1, 255));
            resync_due = 1'b1;
        end else if (flavor >= 88 && flavor < 94) begin
            // Length under six; the receiver clears at the sixth byte
            frame_q[2] = 8'($urandom_range(0, 5));
            n_send     = 6;
        end else if (flavor >= 94) begin
            // Cut the frame off; the next one restarts
            n_send     = $urandom_range(1, n_send - 1);
            resync_due = 1'b1;
        end
        for (int unsigned k = 0; k < n_send; k++) begin
            send_byte((k == 0) ? first_restart : 1'b0, frame_q[k], 1'b0, '0);
        end
    endtask

    // Check each result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: kind %0d value %0d payload_index %0d",
                       o_m_tuser, o_m_tdata[7:0], o_m_tdata[15:8]);
                mismatch_count++;
            end else begin
                head_result = awaited_results.pop_front();
                if (o_m_tuser !== head_result.kind) begin
                    $error("kind: expected %0d, actual %0d", head_result.kind, o_m_tuser);
                    mismatch_count++;
                end
                if (o_m_tdata[7:0] !== head_result.value) begin
                    $error("value: expected %0d, actual %0d",
                           head_result.value, o_m_tdata[7:0]);
                    mismatch_count++;
                end
                if (o_m_tdata[15:8] !== head_result.payload_index) begin
                    $error("payload_index: expected %0d, actual %0d",
                           head_result.payload_index, o_m_tdata[15:8]);
                    mismatch_count++;
                end
            end
        end
    end

    // Output ready: random stall bursts plus one long hold on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                i_m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 8);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Reset, hand-written table, then random phases under new settings
    initial begin
        t_result     typed_res;
        logic [7:0]  cmd_setting;
        logic [7:0]  cap_setting;
        int unsigned phase_goal;
        bit          first_frame;
        model_cmd = 8'h00;
        model_cap = CAPACITY_RESET;
        clear_rx_state();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Hand-written frames under reset settings
        foreach (DIRECTED_ROWS[r]) begin
            typed_res.kind          = DIRECTED_ROWS[r].kind;
            typed_res.value         = DIRECTED_ROWS[r].value;
            typed_res.payload_index = DIRECTED_ROWS[r].index;
            send_byte(DIRECTED_ROWS[r].restart, DIRECTED_ROWS[r].rx_byte,
                      DIRECTED_ROWS[r].typed, typed_res);
        end
        drain_results();

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    cmd_setting = 8'hFF;
                    cap_setting = 8'd0;
                end
                1: begin
                    cmd_setting = 8'h00;
                    cap_setting = 8'd255;
                end
                2: begin
                    cmd_setting = 8'($urandom_range(0, 255));
                    cap_setting = CAPACITY_RESET;
                end
                3: begin
                    cmd_setting = 8'($urandom_range(0, 255));
                    cap_setting = 8'd1;
                end
                4: begin
                    cmd_setting = 8'($urandom_range(0, 255));
                    cap_setting = 8'($urandom_range(2, 20));
                end
                default: begin
                    cmd_setting = 8'h5A;
                    cap_setting = 8'd250;
                end
            endcase
            write_reg(CFG_EXPECTED_COMMAND, cmd_setting);
            write_reg(CFG_PAYLOAD_CAPACITY, cap_setting);
            // No idling in the third phase and the final one
            idle_on = (ph != 2) && (ph != NUM_PHASES - 1);
            if (ph == 3) long_hold_req = 1'b1;
            resync_due  = 1'b1;
            first_frame = 1'b1;
            phase_goal  = bytes_sent + ITEMS_PER_PHASE;
            while (bytes_sent < phase_goal) begin
                send_random_frame((first_frame && (ph == 1 || ph == 2)) ||
                                  $urandom_range(0, 59) == 0);
                first_frame = 1'b0;
            end
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
